// File: hdl/lsce_pkg.sv
package lsce_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int LEVELS_DEF   = 32;

	localparam int DEP_W = 5;
	localparam int POS_W = 32;
	localparam int CNT_W = 7;
	// level numbers with room for LEVELS itself
	localparam int LVL_W = 7;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_CLIP     = 2'd1,
		CMD_CLIP_ALL = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_LIMIT = 2'd0,
		REG_BODY  = 2'd1,
		REG_HEAD  = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DEP_W-1:0] depth;
		logic [POS_W-1:0] position;
		logic             touched;
	} entry_t;

	typedef struct packed {
		logic dep_eq;
		logic pos_eq;
		logic lt;
	} cmp_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic vset;
		logic vclr;
	} tbl_ctl_t;

	typedef struct packed {
		logic             added;
		logic             full_error;
		logic             ev_valid;
		logic [DEP_W-1:0] ev_depth;
		logic [POS_W-1:0] ev_pos;
		logic [CNT_W-1:0] count;
		logic             last;
	} res_t;

endpackage

// File: hdl/lsce_cmp.sv
module lsce_cmp
	import lsce_pkg::*;
(
	input  entry_t           entry,
	input  logic [LVL_W-1:0] key_depth,
	input  logic [POS_W-1:0] key_pos,
	input  logic [POS_W-1:0] best_pos,
	output cmp_t             res
);

	always_comb begin
		res.dep_eq = ({{(LVL_W-DEP_W){1'b0}}, entry.depth} == key_depth);
		res.pos_eq = (entry.position == key_pos);
		res.lt     = (entry.position < best_pos);
	end

endmodule

// File: hdl/lsce_table.sv
module lsce_table
	import lsce_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int IW = $clog2(CAPACITY)
)(
	input  logic                clk,
	input  logic                arst_n,
	input  tbl_ctl_t            ctl,
	input  logic [IW-1:0]       rd_addr,
	input  logic [IW-1:0]       wr_addr,
	input  entry_t              wr_data,
	input  logic [IW-1:0]       v_addr,
	output entry_t              rd_data,
	output logic [CAPACITY-1:0] valid
);

	entry_t              mem_q [CAPACITY];
	logic [CAPACITY-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.vset) begin
			valid_q[v_addr] <= 1'b1;
		end else if (ctl.vclr) begin
			valid_q[v_addr] <= 1'b0;
		end
	end

	assign valid = valid_q;

endmodule

// File: hdl/level_second_chance_evictor.sv
// Second-chance evictor for resident chunks keyed by depth and position. Each
// input transfer carries a command in s_tuser: insert/touch, clip or clip-all.
// A sequencer walks the entry table one entry per cycle through a single read
// port and one shared compare unit.
// Insert takes one pass and then a write. Clip takes one occupancy pass,
// a walk up the run of non-empty depths, and for each depth swept one marking
// pass, one pass per evicted entry (a pass picks the smallest position) and one
// final pass that finds nothing left to evict.
// Clip-all sweeps every depth from LEVELS-1 to head_depth the same way. The
// block takes no new command until the last result of the current one has been
// placed in the output register. Results leave on m_*, last one with m_tlast.
module level_second_chance_evictor
	import lsce_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int LEVELS   = LEVELS_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // depth[4:0], position[36:5], zero pad
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // evicted_depth[4:0], evicted_position[36:5],
	                               // resident_count[43:37], zero pad
	output logic [2:0]  m_tuser,   // added[0], full_error[1], evicted_valid[2]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_FIND  = 7'b0000100,
		ST_NEXT  = 7'b0001000,
		ST_WRITE = 7'b0010000,
		ST_EVICT = 7'b0100000,
		ST_END   = 7'b1000000
	} state_t;

	// what the current table pass is looking for
	typedef enum logic [1:0] {
		M_INS  = 2'd0,
		M_OCC  = 2'd1,
		M_MARK = 2'd2,
		M_MIN  = 2'd3
	} mode_t;

	state_t              st_q;
	mode_t               mode_q;
	cmd_t                cmd_q;
	logic [DEP_W-1:0]    kdep_q;
	logic [POS_W-1:0]    kpos_q;
	logic [CW-1:0]       cnt_q;
	logic                rv_s1;
	logic [IW-1:0]       ridx_s1;
	logic                hit_v_q, free_v_q, best_v_q;
	logic [IW-1:0]       hit_idx_q, free_idx_q, best_idx_q;
	logic [POS_W-1:0]    best_pos_q;
	logic [CAPACITY-1:0] pend_q;
	logic [LEVELS-1:0]   occ_q;
	logic [LVL_W-1:0]    top_q;
	logic [CNT_W-1:0]    resident_q;
	logic [CNT_W-1:0]    limit_q;
	logic [DEP_W-1:0]    body_q, head_q;
	res_t                hold_q, out_q;
	logic                hold_v_q, out_v_q;

	tbl_ctl_t            tctl;
	logic [IW-1:0]       wr_addr, v_addr;
	entry_t              wr_data, rd_data;
	logic [CAPACITY-1:0] valid;
	cmp_t                cmp;
	logic [LVL_W-1:0]    cur, key_depth;
	logic                rd_en, ent_v, scan_end, mark_wb, force_ev, slot_free;
	logic                over_limit, accept, emit;
	cmd_t                in_cmd;

	function automatic logic occ_at(input logic [LEVELS-1:0] occ, input logic [LVL_W-1:0] l);
		logic r;
		r = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (l == LVL_W'(i)) r = occ[i];
		end
		return r;
	endfunction

	assign in_cmd     = cmd_t'(s_tuser);
	assign s_tready   = (st_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign cur        = top_q - LVL_W'(1);
	assign key_depth  = (mode_q == M_INS) ? {{(LVL_W-DEP_W){1'b0}}, kdep_q} : cur;
	assign rd_en      = (st_q == ST_SCAN) && (cnt_q < CW'(CAPACITY));
	assign ent_v      = valid[ridx_s1];
	assign scan_end   = (st_q == ST_SCAN) && rv_s1 && (ridx_s1 == IW'(CAPACITY - 1));
	assign force_ev   = (cmd_q == CMD_CLIP_ALL);
	assign slot_free  = !out_v_q || m_tready;
	assign over_limit = (resident_q > limit_q);
	// touched entry at the swept depth gets its second chance
	assign mark_wb    = (st_q == ST_SCAN) && (mode_q == M_MARK) && rv_s1 && ent_v
	                    && cmp.dep_eq && !force_ev && rd_data.touched;
	// a result moves into the output register
	assign emit       = ((st_q == ST_EVICT) && best_v_q && hold_v_q && slot_free)
	                    || ((st_q == ST_END) && slot_free);

	lsce_cmp u_cmp (
		.entry     (rd_data),
		.key_depth (key_depth),
		.key_pos   (kpos_q),
		.best_pos  (best_pos_q),
		.res       (cmp)
	);

	lsce_table #(.CAPACITY(CAPACITY)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tctl),
		.rd_addr (cnt_q[IW-1:0]),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.v_addr  (v_addr),
		.rd_data (rd_data),
		.valid   (valid)
	);

	// table port control
	always_comb begin
		tctl.rd   = rd_en;
		tctl.vset = (st_q == ST_WRITE) && (hit_v_q || free_v_q);
		tctl.vclr = (st_q == ST_EVICT) && best_v_q && (!hold_v_q || slot_free);
		tctl.wr   = tctl.vset || mark_wb;
		if (st_q == ST_WRITE) begin
			wr_addr = hit_v_q ? hit_idx_q : free_idx_q;
			wr_data = '{depth: kdep_q, position: kpos_q, touched: 1'b1};
		end else begin
			wr_addr = ridx_s1;
			wr_data = '{depth: rd_data.depth, position: rd_data.position, touched: 1'b0};
		end
		v_addr = (st_q == ST_WRITE) ? wr_addr : best_idx_q;
	end

	// configuration registers; the user must write them only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CNT_W'(32);
			body_q  <= '0;
			head_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LIMIT: limit_q <= cfg_data;
				REG_BODY:  body_q  <= cfg_data[DEP_W-1:0];
				REG_HEAD:  head_q  <= cfg_data[DEP_W-1:0];
				default:   ;
			endcase
		end
	end

	// read pipeline: data for ridx_s1 is valid while rv_s1 is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= cnt_q[IW-1:0];
	end

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			mode_q     <= M_INS;
			cmd_q      <= CMD_NONE;
			kdep_q     <= '0;
			kpos_q     <= '0;
			cnt_q      <= '0;
			hit_v_q    <= 1'b0;
			free_v_q   <= 1'b0;
			best_v_q   <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			best_idx_q <= '0;
			best_pos_q <= '0;
			pend_q     <= '0;
			occ_q      <= '0;
			top_q      <= '0;
			resident_q <= '0;
			hold_q     <= '0;
			out_q      <= '0;
			hold_v_q   <= 1'b0;
		end else begin
			if (rd_en) cnt_q <= cnt_q + CW'(1);

			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= in_cmd;
						kdep_q   <= s_tdata[4:0];
						kpos_q   <= s_tdata[36:5];
						hold_v_q <= 1'b0;
						cnt_q    <= '0;
						unique case (in_cmd)
							CMD_INSERT: begin
								hit_v_q  <= 1'b0;
								free_v_q <= 1'b0;
								mode_q   <= M_INS;
								st_q     <= ({{(LVL_W-DEP_W){1'b0}}, s_tdata[4:0]}
								             < LVL_W'(LEVELS)) ? ST_SCAN : ST_END;
							end
							CMD_CLIP: begin
								occ_q  <= '0;
								mode_q <= M_OCC;
								st_q   <= (over_limit && ({{(LVL_W-DEP_W){1'b0}}, body_q}
								           < LVL_W'(LEVELS))) ? ST_SCAN : ST_END;
							end
							CMD_CLIP_ALL: begin
								top_q <= LVL_W'(LEVELS);
								st_q  <= ST_NEXT;
							end
							default: st_q <= ST_END;
						endcase
					end
				end

				ST_SCAN: begin
					if (rv_s1) begin
						unique case (mode_q)
							M_INS: begin
								if (ent_v && cmp.dep_eq && cmp.pos_eq) begin
									hit_v_q   <= 1'b1;
									hit_idx_q <= ridx_s1;
								end
								if (!ent_v && !free_v_q) begin
									free_v_q   <= 1'b1;
									free_idx_q <= ridx_s1;
								end
							end
							M_OCC: begin
								for (int l = 0; l < LEVELS; l++) begin
									if (ent_v && ({{(LVL_W-DEP_W){1'b0}}, rd_data.depth}
									              == LVL_W'(l))) occ_q[l] <= 1'b1;
								end
							end
							M_MARK: begin
								if (ent_v && cmp.dep_eq && (force_ev || !rd_data.touched))
									pend_q[ridx_s1] <= 1'b1;
							end
							M_MIN: begin
								if (pend_q[ridx_s1] && (!best_v_q || cmp.lt)) begin
									best_v_q   <= 1'b1;
									best_idx_q <= ridx_s1;
									best_pos_q <= rd_data.position;
								end
							end
							default: ;
						endcase
					end
					if (scan_end) begin
						unique case (mode_q)
							M_INS:  st_q <= ST_WRITE;
							M_OCC: begin
								top_q <= {{(LVL_W-DEP_W){1'b0}}, body_q};
								st_q  <= ST_FIND;
							end
							M_MARK: begin
								mode_q   <= M_MIN;
								best_v_q <= 1'b0;
								cnt_q    <= '0;
							end
							M_MIN:  st_q <= ST_EVICT;
							default: st_q <= ST_END;
						endcase
					end
				end

				// climb the unbroken run of non-empty depths
				ST_FIND: begin
					if ((top_q < LVL_W'(LEVELS)) && occ_at(occ_q, top_q)) begin
						top_q <= top_q + LVL_W'(1);
					end else begin
						st_q <= ST_NEXT;
					end
				end

				// top_q is one above the next depth to sweep
				ST_NEXT: begin
					if (force_ev ? (top_q > {{(LVL_W-DEP_W){1'b0}}, head_q})
					             : ((top_q > {{(LVL_W-DEP_W){1'b0}}, body_q}) && over_limit
					                && occ_at(occ_q, cur))) begin
						pend_q <= '0;
						mode_q <= M_MARK;
						cnt_q  <= '0;
						st_q   <= ST_SCAN;
					end else begin
						st_q <= ST_END;
					end
				end

				ST_WRITE: begin
					hold_q <= '{
						added:      !hit_v_q && free_v_q,
						full_error: !hit_v_q && !free_v_q,
						ev_valid:   1'b0,
						ev_depth:   DEP_W'(0),
						ev_pos:     POS_W'(0),
						count:      (!hit_v_q && free_v_q) ? resident_q + CNT_W'(1)
						                                   : resident_q,
						last:       1'b0
					};
					hold_v_q <= 1'b1;
					if (!hit_v_q && free_v_q) resident_q <= resident_q + CNT_W'(1);
					st_q <= ST_END;
				end

				// one eviction held back so that the final one can carry last
				ST_EVICT: begin
					if (!best_v_q) begin
						top_q <= cur;
						st_q  <= ST_NEXT;
					end else if (!hold_v_q || slot_free) begin
						if (hold_v_q) begin
							out_q <= hold_q;
						end
						hold_q <= '{
							added:      1'b0,
							full_error: 1'b0,
							ev_valid:   1'b1,
							ev_depth:   cur[DEP_W-1:0],
							ev_pos:     best_pos_q,
							count:      (resident_q != CNT_W'(0)) ? resident_q - CNT_W'(1)
							                                      : CNT_W'(0),
							last:       1'b0
						};
						hold_v_q <= 1'b1;
						if (resident_q != '0) resident_q <= resident_q - CNT_W'(1);
						pend_q[best_idx_q] <= 1'b0;
						best_v_q <= 1'b0;
						cnt_q    <= '0;
						st_q     <= ST_SCAN;
					end
				end

				ST_END: begin
					if (slot_free) begin
						if (hold_v_q) begin
							out_q <= '{
								added:      hold_q.added,
								full_error: hold_q.full_error,
								ev_valid:   hold_q.ev_valid,
								ev_depth:   hold_q.ev_depth,
								ev_pos:     hold_q.ev_pos,
								count:      hold_q.count,
								last:       1'b1
							};
						end else begin
							out_q <= '{
								added:      1'b0,
								full_error: 1'b0,
								ev_valid:   1'b0,
								ev_depth:   DEP_W'(0),
								ev_pos:     POS_W'(0),
								count:      resident_q,
								last:       1'b1
							};
						end
						hold_v_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end

				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0000, out_q.count, out_q.ev_pos, out_q.ev_depth};
	assign m_tuser  = {out_q.ev_valid, out_q.full_error, out_q.added};
	assign m_tlast  = out_q.last;

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid) == int'(resident_q))
		else $error("resident count differs from valid entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		resident_q <= CNT_W'(CAPACITY))
		else $error("resident count beyond capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("sequencer did not start on accepted command");

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !hold_v_q)
		else $error("held result left behind at idle");
`endif

endmodule
